>>> sv/shpd_pkg.sv
`default_nettype none

package shpd_pkg;

  // Field widths of the input and result beats
  localparam int PAL_NUM_W = 4;
  localparam int SLOT_W    = 4;
  localparam int COLOR_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int PIXEL_W   = 24;

  // Palette geometry
  localparam int MAX_PALETTES     = 16;
  localparam int NUM_PALETTES_DEF = 16;

  // Slots are split into four banks by slot bits 3:2, two bits of address each
  localparam int SLOT_BANKS = 4;
  localparam int BANK_SEL_W = 2;
  localparam int FIELD_W    = 2;

  // Item kinds carried on the mode field
  localparam logic MODE_DECODE = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  // In 640 mode the 2-bit field that feeds each bank sits at this bit offset:
  // slots 0..3 take bits 3:2, 4..7 bits 1:0, 8..11 bits 7:6, 12..15 bits 5:4
  localparam logic [2:0] BANK_SHIFT [SLOT_BANKS] = '{3'd2, 3'd0, 3'd6, 3'd4};

  // Widen a 12-bit color to 24-bit RGB by repeating each nibble
  function automatic logic [PIXEL_W-1:0] widen(input logic [COLOR_W-1:0] c);
    widen = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> sv/super_hires_pixel_palette_decode.sv
// Channel | Signals                                             | Beat carries
// --------+-----------------------------------------------------+----------------------------
// in      | in_valid, in_stall, mode, palette_number,           | one palette write or one
//         | color_index, color_value, pixel_byte, wide_mode     | screen byte to decode
// out     | out_valid, out_stall, pixel_first .. pixel_fourth   | four 24-bit RGB pixels
//
// One input beat per cycle while in_stall is low. A decoded byte passes through the
// registered palette bank read, then color select and widening into the output register.
// Palette writes give no output beat; a decode taken the cycle after a write sees it.
// rst is synchronous; it drops both pipeline stages and marks every palette entry
// as cleared at once, so no clearing pass is needed.
// A stalled output beat freezes the whole pipe; in_stall follows out_stall then.
`default_nettype none

module super_hires_pixel_palette_decode #(
  parameter int NUM_PALETTES = shpd_pkg::NUM_PALETTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic [shpd_pkg::PAL_NUM_W-1:0] palette_number,
  input  wire logic [shpd_pkg::SLOT_W-1:0]    color_index,
  input  wire logic [shpd_pkg::COLOR_W-1:0]   color_value,
  input  wire logic [shpd_pkg::BYTE_W-1:0]    pixel_byte,
  input  wire logic                           wide_mode,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [shpd_pkg::PIXEL_W-1:0]        pixel_first,
  output logic [shpd_pkg::PIXEL_W-1:0]        pixel_second,
  output logic [shpd_pkg::PIXEL_W-1:0]        pixel_third,
  output logic [shpd_pkg::PIXEL_W-1:0]        pixel_fourth
);

  localparam int PAL_W      = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
  localparam int AW         = PAL_W + shpd_pkg::FIELD_W;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int CMP_W      = shpd_pkg::PAL_NUM_W + 1;
  localparam int NB         = shpd_pkg::SLOT_BANKS;

  logic                  adv;
  logic                  in_beat;
  logic                  pal_ok;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         addr_a [NB];
  logic [AW-1:0]         addr_b;

  // Stage 1: registered bank reads and what is needed to pick from them
  logic                          s1_valid;
  logic                          s1_wide;
  logic                          s1_ok;
  logic [shpd_pkg::BANK_SEL_W-1:0] s1_hi_bank;
  logic [shpd_pkg::BANK_SEL_W-1:0] s1_lo_bank;
  logic [shpd_pkg::COLOR_W-1:0]  rd_a [NB];
  logic [shpd_pkg::COLOR_W-1:0]  rd_b [NB];
  logic [NB-1:0]                 vld_a;
  logic [NB-1:0]                 vld_b;

  logic [shpd_pkg::COLOR_W-1:0]  col_a [NB];
  logic [shpd_pkg::COLOR_W-1:0]  col_b [NB];
  logic [shpd_pkg::PIXEL_W-1:0]  pix_hi;
  logic [shpd_pkg::PIXEL_W-1:0]  pix_lo;

  // Advance the whole pipe unless a finished beat is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_beat  = in_valid && adv;

  // Palettes beyond the configured count are never written and read as black
  assign pal_ok  = {1'b0, palette_number} < CMP_W'(NUM_PALETTES);
  assign wr_en   = in_beat && (mode == shpd_pkg::MODE_WRITE) && pal_ok;
  assign wr_addr = {palette_number[PAL_W-1:0], color_index[shpd_pkg::FIELD_W-1:0]};

  // Port A: per-bank field in 640 mode, high nibble slot in 320 mode.
  // Port B: low nibble slot in 320 mode.
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      if (wide_mode) begin
        addr_a[k] = {palette_number[PAL_W-1:0],
                     shpd_pkg::FIELD_W'(pixel_byte >> shpd_pkg::BANK_SHIFT[k])};
      end else begin
        addr_a[k] = {palette_number[PAL_W-1:0], pixel_byte[5:4]};
      end
    end
    addr_b = {palette_number[PAL_W-1:0], pixel_byte[1:0]};
  end

  // Four palette banks, one write port and two read ports each
  for (genvar k = 0; k < NB; k++) begin : g_bank
    logic [shpd_pkg::COLOR_W-1:0] bank_mem [BANK_DEPTH];
    logic [BANK_DEPTH-1:0]        bank_vld;
    logic                         bank_we;

    assign bank_we = wr_en &&
                     (color_index[shpd_pkg::SLOT_W-1 -: shpd_pkg::BANK_SEL_W] ==
                      shpd_pkg::BANK_SEL_W'(k));

    // Write one color; read both ports when the pipe moves
    always_ff @(posedge clk) begin
      if (bank_we) begin
        bank_mem[wr_addr] <= color_value;
      end
      if (adv) begin
        rd_a[k] <= bank_mem[addr_a[k]];
        rd_b[k] <= bank_mem[addr_b];
      end
    end

    // Mark entries written since reset; an unmarked entry reads as zero
    always_ff @(posedge clk) begin
      if (rst) begin
        bank_vld <= '0;
        vld_a[k] <= 1'b0;
        vld_b[k] <= 1'b0;
      end else begin
        if (bank_we) begin
          bank_vld[wr_addr] <= 1'b1;
        end
        if (adv) begin
          vld_a[k] <= bank_vld[addr_a[k]];
          vld_b[k] <= bank_vld[addr_b];
        end
      end
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_beat && (mode == shpd_pkg::MODE_DECODE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wide    <= wide_mode;
      s1_ok      <= pal_ok;
      s1_hi_bank <= pixel_byte[7:6];
      s1_lo_bank <= pixel_byte[3:2];
    end
  end

  // Zero out unwritten entries and out-of-range palettes
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      col_a[k] = (s1_ok && vld_a[k]) ? rd_a[k] : '0;
      col_b[k] = (s1_ok && vld_b[k]) ? rd_b[k] : '0;
    end
    pix_hi = shpd_pkg::widen(col_a[s1_hi_bank]);
    pix_lo = shpd_pkg::widen(col_b[s1_lo_bank]);
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      if (s1_wide) begin
        pixel_first  <= shpd_pkg::widen(col_a[2]);
        pixel_second <= shpd_pkg::widen(col_a[3]);
        pixel_third  <= shpd_pkg::widen(col_a[0]);
        pixel_fourth <= shpd_pkg::widen(col_a[1]);
      end else begin
        pixel_first  <= pix_hi;
        pixel_second <= pix_hi;
        pixel_third  <= pix_lo;
        pixel_fourth <= pix_lo;
      end
    end
  end

  // A decode beat in stage 1 moves into the output when the pipe advances
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && adv |=> out_valid)
    else $error("decoded beat lost between stage 1 and output");

  // A palette write never turns into an output beat
  a_write_no_beat: assert property (@(posedge clk) disable iff (rst)
    in_beat && (mode == shpd_pkg::MODE_WRITE) |=> !s1_valid)
    else $error("palette write produced a pipeline beat");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  // A held output beat freezes stage 1
  a_hold_s1: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s1_valid))
    else $error("stage 1 moved while output was held");

endmodule

`default_nettype wire
